// ===== design/ta2_pkg.sv =====
// ----------------------------------------------------------------------------
// ta2_pkg
// Shared types, constants and the arctangent table for the two-argument
// arctangent pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ta2_pkg;

  // widths of the datapath
  localparam int InW    = 16;  // input component width
  localparam int MagW   = 17;  // magnitude width, holds 32768
  localparam int QuoW   = 9;   // ratio 0..256
  localparam int LutW   = 10;  // table values up to 785
  localparam int AngleW = 14;  // result width

  // quotient bits resolved in each divider stage
  localparam int DivStepsPerStage = 3;

  // angle constants in milliradians
  localparam logic signed [AngleW-1:0] HalfPiMrad = 14'sd1571;
  localparam logic signed [AngleW-1:0] PiMrad     = 14'sd3142;
  localparam logic signed [AngleW-1:0] TwoPiMrad  = 14'sd6283;

  // per-item side information that rides along the pipeline
  typedef struct packed {
    logic swap;    // |y| > |x|, ratio taken on x/y
    logic x_neg;
    logic y_neg;
    logic x_zero;
    logic y_zero;
  } ta2_flags_t;

  // arctangent of k/16 for k = 0..16, in milliradians
  function automatic logic [LutW-1:0] lut_entry(input logic [4:0] idx);
    logic [LutW-1:0] val;
    unique case (idx)
      5'd0:    val = 10'd0;
      5'd1:    val = 10'd62;
      5'd2:    val = 10'd124;
      5'd3:    val = 10'd185;
      5'd4:    val = 10'd245;
      5'd5:    val = 10'd303;
      5'd6:    val = 10'd359;
      5'd7:    val = 10'd412;
      5'd8:    val = 10'd464;
      5'd9:    val = 10'd512;
      5'd10:   val = 10'd559;
      5'd11:   val = 10'd602;
      5'd12:   val = 10'd644;
      5'd13:   val = 10'd682;
      5'd14:   val = 10'd719;
      5'd15:   val = 10'd753;
      default: val = 10'd785;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== design/ta2_prep.sv =====
// ----------------------------------------------------------------------------
// ta2_prep
// Input stage: takes magnitudes, orders them into dividend and divisor and
// captures the sign and zero flags.
// ----------------------------------------------------------------------------
`default_nettype none

module ta2_prep
  import ta2_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   valid_i,
  input  wire logic signed [InW-1:0]  y_value_i,
  input  wire logic signed [InW-1:0]  x_value_i,
  output logic                        valid_o,
  output logic [MagW-1:0]             rem_o,
  output logic [MagW-1:0]             den_o,
  output ta2_flags_t                  flags_o
);

  logic             valid_q;
  logic [MagW-1:0]  rem_q, rem_d;
  logic [MagW-1:0]  den_q, den_d;
  ta2_flags_t       flags_q, flags_d;
  logic [MagW-1:0]  ay, ax;

  // take magnitudes at full width so -32768 maps to 32768
  always_comb begin
    ay = y_value_i[InW-1] ? (MagW'(0) - {1'b1, y_value_i}) : {1'b0, y_value_i};
    ax = x_value_i[InW-1] ? (MagW'(0) - {1'b1, x_value_i}) : {1'b0, x_value_i};
  end

  // order the pair so the smaller magnitude is divided by the larger
  always_comb begin
    flags_d.swap   = (ay > ax);
    flags_d.x_neg  = x_value_i[InW-1];
    flags_d.y_neg  = y_value_i[InW-1];
    flags_d.x_zero = (x_value_i == '0);
    flags_d.y_zero = (y_value_i == '0);
    rem_d = flags_d.swap ? ax : ay;
    den_d = flags_d.swap ? ay : ax;
  end

  // advance valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // hold payload while stalled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q   <= rem_d;
      den_q   <= den_d;
      flags_q <= flags_d;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign flags_o = flags_q;

endmodule

`default_nettype wire

// ===== design/ta2_div_stage.sv =====
// ----------------------------------------------------------------------------
// ta2_div_stage
// One stage of the restoring divider: resolves a few quotient bits of
// (small * 256) / large and registers the partial remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module ta2_div_stage
  import ta2_pkg::*;
#(
  parameter bit First = 1'b0  // first stage: no shift before the leading step
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [MagW-1:0]  rem_i,
  input  wire logic [MagW-1:0]  den_i,
  input  wire logic [QuoW-1:0]  quo_i,
  input  wire ta2_flags_t       flags_i,
  output logic                  valid_o,
  output logic [MagW-1:0]       rem_o,
  output logic [MagW-1:0]       den_o,
  output logic [QuoW-1:0]       quo_o,
  output ta2_flags_t            flags_o
);

  logic             valid_q;
  logic [MagW-1:0]  rem_q, rem_d;
  logic [MagW-1:0]  den_q;
  logic [QuoW-1:0]  quo_q, quo_d;
  ta2_flags_t       flags_q;

  // compare and subtract; remainder stays below the divisor, so the shift fits
  always_comb begin
    rem_d = rem_i;
    quo_d = quo_i;
    for (int s = 0; s < DivStepsPerStage; s++) begin
      if (!(First && (s == 0))) begin
        rem_d = {rem_d[MagW-2:0], 1'b0};
      end
      if (rem_d >= den_i) begin
        rem_d = rem_d - den_i;
        quo_d = {quo_d[QuoW-2:0], 1'b1};
      end else begin
        quo_d = {quo_d[QuoW-2:0], 1'b0};
      end
    end
  end

  // advance valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // hold payload while stalled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q   <= rem_d;
      den_q   <= den_i;
      quo_q   <= quo_d;
      flags_q <= flags_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign quo_o   = quo_q;
  assign flags_o = flags_q;

endmodule

`default_nettype wire

// ===== design/ta2_angle.sv =====
// ----------------------------------------------------------------------------
// ta2_angle
// Table lookup with linear interpolation, then octant and quadrant folding
// into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ta2_angle
  import ta2_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    valid_i,
  input  wire logic [QuoW-1:0]         quo_i,
  input  wire ta2_flags_t              flags_i,
  output logic                         valid_o,
  output logic signed [AngleW-1:0]     angle_o
);

  logic                     lut_valid_q;
  logic [LutW-1:0]          lut_q, lut_d;
  ta2_flags_t               lut_flags_q;
  logic                     out_valid_q;
  logic signed [AngleW-1:0] angle_q, angle_d;

  logic [4:0]       idx;
  logic [3:0]       frac;
  logic [LutW-1:0]  lo, hi, diff;
  logic [LutW-1:0]  prod;
  logic signed [AngleW-1:0] oct;

  // angle within the first quadrant
  function automatic logic signed [AngleW-1:0] lut_q_ext(input logic swap,
                                                        input logic [LutW-1:0] v);
    logic signed [AngleW-1:0] ext;
    ext = $signed({{(AngleW-LutW){1'b0}}, v});
    return swap ? (HalfPiMrad - ext) : ext;
  endfunction

  // interpolate between neighbors; at ratio 256 the fraction is zero
  always_comb begin
    idx   = quo_i[QuoW-1:4];
    frac  = quo_i[3:0];
    lo    = lut_entry(idx);
    hi    = lut_entry(idx + 5'd1);
    diff  = hi - lo;
    prod  = LutW'(diff[5:0] * frac);
    lut_d = lo + LutW'(prod[LutW-1:4]);
  end

  // fold into the full circle, axes first
  always_comb begin
    oct = lut_q_ext(lut_flags_q.swap, lut_q);
    priority if (lut_flags_q.x_zero) begin
      angle_d = lut_flags_q.y_neg ? -HalfPiMrad : HalfPiMrad;
    end else if (lut_flags_q.y_zero) begin
      angle_d = lut_flags_q.x_neg ? PiMrad : '0;
    end else if (lut_flags_q.x_neg) begin
      angle_d = lut_flags_q.y_neg ? (PiMrad + oct) : (PiMrad - oct);
    end else if (lut_flags_q.y_neg) begin
      angle_d = TwoPiMrad - oct;
    end else begin
      angle_d = oct;
    end
  end

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lut_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      lut_valid_q <= valid_i;
      out_valid_q <= lut_valid_q;
    end
  end

  // hold payload while stalled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lut_q       <= lut_d;
      lut_flags_q <= flags_i;
      angle_q     <= angle_d;
    end
  end

  assign valid_o = out_valid_q;
  assign angle_o = angle_q;

endmodule

`default_nettype wire

// ===== design/table_arctangent_two_arg.sv =====
// ----------------------------------------------------------------------------
// table_arctangent_two_arg
// Two-argument arctangent in milliradians: pipelined ratio divider, 17-entry
// table with linear interpolation, quadrant folding to 0..2pi; -pi/2 at x=0,y<0.
// ----------------------------------------------------------------------------
//
//   channel | handshake              | payload
//   --------+------------------------+---------------------------------
//   in      | in_valid_i / in_ready_o  | y_value_i, x_value_i (s16)
//   out     | out_valid_o / out_ready_i| angle_mrad_o (s14)
//
// One pair enters per cycle unless the output is held; six register stages
// deep: prep, divider stages u_div0 to u_div2, table lookup and output fold.
// The divider resolves nine quotient bits, three per stage.
// Reset clears only the valid bits; no table or memory needs filling.
// A stall on the output freezes every stage at once; nothing is dropped.
//
`default_nettype none

module table_arctangent_two_arg
  import ta2_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic signed [InW-1:0] y_value_i,
  input  wire logic signed [InW-1:0] x_value_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic signed [AngleW-1:0]   angle_mrad_o
);

  logic en;

  logic             p_valid, d1_valid, d2_valid, d3_valid;
  logic [MagW-1:0]  p_rem, d1_rem, d2_rem, d3_rem;
  logic [MagW-1:0]  p_den, d1_den, d2_den, d3_den;
  logic [QuoW-1:0]  d1_quo, d2_quo, d3_quo;
  ta2_flags_t       p_flags, d1_flags, d2_flags, d3_flags;

  // advance the whole pipe unless the output beat is held
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  ta2_prep u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .y_value_i (y_value_i),
    .x_value_i (x_value_i),
    .valid_o   (p_valid),
    .rem_o     (p_rem),
    .den_o     (p_den),
    .flags_o   (p_flags)
  );

  ta2_div_stage #(.First(1'b1)) u_div0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p_valid),
    .rem_i   (p_rem),
    .den_i   (p_den),
    .quo_i   ('0),
    .flags_i (p_flags),
    .valid_o (d1_valid),
    .rem_o   (d1_rem),
    .den_o   (d1_den),
    .quo_o   (d1_quo),
    .flags_o (d1_flags)
  );

  ta2_div_stage #(.First(1'b0)) u_div1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d1_valid),
    .rem_i   (d1_rem),
    .den_i   (d1_den),
    .quo_i   (d1_quo),
    .flags_i (d1_flags),
    .valid_o (d2_valid),
    .rem_o   (d2_rem),
    .den_o   (d2_den),
    .quo_o   (d2_quo),
    .flags_o (d2_flags)
  );

  ta2_div_stage #(.First(1'b0)) u_div2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d2_valid),
    .rem_i   (d2_rem),
    .den_i   (d2_den),
    .quo_i   (d2_quo),
    .flags_i (d2_flags),
    .valid_o (d3_valid),
    .rem_o   (d3_rem),
    .den_o   (d3_den),
    .quo_o   (d3_quo),
    .flags_o (d3_flags)
  );

  ta2_angle u_angle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d3_valid),
    .quo_i   (d3_quo),
    .flags_i (d3_flags),
    .valid_o (out_valid_o),
    .angle_o (angle_mrad_o)
  );

  // ratio of smaller to larger magnitude never exceeds 256 on a live item with nonzero x
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d3_valid && !d3_flags.x_zero) |-> (d3_quo <= 9'd256))
    else $error("divider ratio out of range");

  // results stay inside 0..2pi, or negative half pi on the lower y axis
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((angle_mrad_o >= 14'sd0 && angle_mrad_o <= TwoPiMrad) ||
                     (angle_mrad_o == -HalfPiMrad)))
    else $error("angle out of range");

  // a held output freezes the divider stages too
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(d3_quo) && $stable(d3_valid) && $stable(d2_rem)))
    else $error("pipeline moved during stall");

  // remainder stays below the divisor after division stages two and three, x nonzero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d2_valid && !d2_flags.x_zero) |-> (d2_rem < d2_den))
    else $error("partial remainder not reduced");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d3_valid && !d3_flags.x_zero) |-> (d3_rem < d3_den))
    else $error("final remainder not reduced");

endmodule

`default_nettype wire
